// ===== rtl/core/sha_pkg.sv =====
`default_nettype none
package sha_pkg;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS = 64;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LENGTH_POS = 6'd56;

  typedef logic [31:0] word_t;

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,32'h923f82a4,
    32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,32'h72be5d74,32'h80deb1fe,
    32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,
    32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
    32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,
    32'h53380d13,32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,32'h19a4c116,
    32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
    32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,32'h90befffa,32'ha4506ceb,32'hbef9a3f7,
    32'hc67178f2};

  localparam word_t INITIAL_VALUE [8] = '{
    32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
    32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

  typedef struct packed {
    logic start;
    logic load_iv;
  } comp_ctrl_t;
endpackage
`default_nettype wire

// ===== rtl/core/sha_if.sv =====
`default_nettype none
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       byte_present;
  logic       first_of_message;
  logic       last_of_message;
  modport source (output valid, message_byte, byte_present, first_of_message,
                  last_of_message, input ready);
  modport sink (input valid, message_byte, byte_present, first_of_message,
                last_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/sha_compress.sv =====
`default_nettype none
// One round per cycle; message schedule in a 16-word shift window.
module sha_compress (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sha_pkg::comp_ctrl_t ctrl,
  input  wire logic [511:0]       block,
  output logic                    busy,
  output sha_pkg::word_t          hash [8]
);
  sha_pkg::word_t w [16];
  sha_pkg::word_t v [8];
  logic [5:0] round;
  sha_pkg::word_t s0, s1, wn, t1, t2, ch, maj, e, a;

  function automatic sha_pkg::word_t rotr(sha_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wn = s1 + w[9] + s0 + w[0];
    e = v[4];
    a = v[0];
    ch = (e & v[5]) ^ (~e & v[6]);
    maj = (a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]);
    t1 = v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch + sha_pkg::ROUND_K[round] + w[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + maj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      round <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::INITIAL_VALUE[i];
    end else if (ctrl.load_iv) begin
      for (int i = 0; i < 8; i++) hash[i] <= sha_pkg::INITIAL_VALUE[i];
    end else if (ctrl.start && !busy) begin
      busy <= 1'b1;
      round <= '0;
      for (int i = 0; i < 16; i++) w[i] <= block[511 - 32*i -: 32];
      for (int i = 0; i < 8; i++) v[i] <= hash[i];
    end else if (busy) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
      // round stays at 63 after the last round to mark the pending feed-forward
      if (round == 6'd63) busy <= 1'b0;
      else round <= round + 6'd1;
    end else if (round == 6'd63) begin
      // Feed-forward into the hash after the last round.
      for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
      round <= '0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) busy && round == 6'd63 |=> !busy);
  assert property (@(posedge clk) disable iff (rst) !busy && round != 6'd0 |=> round == 6'd0);
  assert property (@(posedge clk) disable iff (rst) ctrl.start && !busy && !ctrl.load_iv
                   |=> busy && round == 6'd0);
endmodule
`default_nettype wire

// ===== rtl/core/sha256_stream_hasher_top.sv =====
`default_nettype none
// SHA-256 hasher over a byte stream.
// Input channel: one transaction per message byte (byte_present) with first and
// last flags. A first flag restarts from the initial value; a last flag pads,
// finishes and produces eight output transactions, digest word 0 first, then
// restarts. A last transaction with no byte finishes what came so far.
// Byte transactions are taken one per handshake, except that the 64th byte of a block
// holds the input for the 64-round compression: not ready through start, 64 rounds
// and feed-forward, set by the single round unit (one round per cycle).
// A last transaction costs one or two compressions (two when the length needs a
// second block or when the last transaction also fills a block); the first digest
// word is valid once they are done, followed by the eight output transactions at
// one per cycle at best.
// Output: digest words stay in the output register while the receiver stalls;
// the input is not ready until all eight words are taken.
// Reset (rst, synchronous) loads the initial value and clears the byte and bit
// counts; the block buffer holds no defined data until written.
module sha256_stream_hasher_top (
  input wire logic clk,
  input wire logic rst,
  sha_in_if.sink   in_ch,
  sha_out_if.source out_ch
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RUN   = 7'b0000010,
    S_WAIT  = 7'b0000100,
    S_PAD   = 7'b0001000,
    S_RUN2  = 7'b0010000,
    S_WAIT2 = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  sha_pkg::word_t buffer [16];   // block as big-endian words
  logic [5:0] fill;
  logic [5:0] wr_pos;            // byte slot of an incoming byte, after any restart
  logic [63:0] bit_count;
  logic finishing;          // a last flag is pending behind a compression
  logic second;             // the padded length block still follows
  logic [2:0] out_idx;
  logic [511:0] block;
  logic busy;
  sha_pkg::word_t hash [8];
  sha_pkg::comp_ctrl_t ctrl;
  logic accept;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign wr_pos = in_ch.first_of_message ? 6'd0 : fill;

  always_comb begin
    for (int i = 0; i < 16; i++) block[511 - 32*i -: 32] = buffer[i];
  end

  always_comb begin
    ctrl.start = (state == S_RUN) || (state == S_RUN2);
    ctrl.load_iv = (accept && in_ch.first_of_message) ||
                   (state == S_OUT && out_ch.ready && out_idx == 3'd7);
  end

  sha_compress u_comp (.clk, .rst, .ctrl, .block, .busy, .hash);

  assign out_ch.valid = (state == S_OUT);
  assign out_ch.digest_word = hash[out_idx];
  assign out_ch.word_index = out_idx;
  assign out_ch.last_word = (out_idx == 3'd7);

  // Padding: 0x80 at fill, zeros after; length in the last eight bytes.
  always_ff @(posedge clk) begin
    if (accept && in_ch.byte_present)
      buffer[wr_pos[5:2]][5'd31 - {wr_pos[1:0], 3'b000} -: 8] <= in_ch.message_byte;
    if (state == S_PAD) begin
      for (int i = 0; i < 64; i++) begin
        if (second) begin
          if (i < 56) buffer[i >> 2][31 - 8*(i & 3) -: 8] <= 8'h00;
          else buffer[i >> 2][31 - 8*(i & 3) -: 8] <= bit_count[63 - 8*(i-56) -: 8];
        end else if (6'(i) == fill) begin
          buffer[i >> 2][31 - 8*(i & 3) -: 8] <= sha_pkg::PAD_BYTE;
        end else if (6'(i) > fill) begin
          buffer[i >> 2][31 - 8*(i & 3) -: 8] <= (i >= 56 && fill < sha_pkg::LENGTH_POS) ?
                       bit_count[63 - 8*(i-56) -: 8] : 8'h00;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      bit_count <= '0;
      finishing <= 1'b0;
      second <= 1'b0;
      out_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (accept) begin
          logic [5:0] f;
          logic [63:0] b;
          f = in_ch.first_of_message ? 6'd0 : fill;
          b = in_ch.first_of_message ? 64'd0 : bit_count;
          if (in_ch.byte_present) begin
            b = b + 64'd8;
            fill <= f + 6'd1;
            bit_count <= b;
            if (f == 6'd63) begin
              finishing <= in_ch.last_of_message;
              state <= S_RUN;
            end else if (in_ch.last_of_message) state <= S_PAD;
          end else begin
            fill <= f;
            bit_count <= b;
            if (in_ch.last_of_message) state <= S_PAD;
          end
        end
        S_RUN: state <= S_WAIT;
        S_WAIT: if (!busy && !ctrl.start) begin
          // feed-forward lands this cycle
          state <= finishing ? S_PAD : S_IDLE;
          finishing <= 1'b0;
        end
        S_PAD: begin
          if (!second && fill >= sha_pkg::LENGTH_POS) second <= 1'b1;
          else second <= 1'b0;
          state <= S_RUN2;
        end
        S_RUN2: state <= S_WAIT2;
        S_WAIT2: if (!busy) begin
          state <= second ? S_PAD : S_OUT;
          out_idx <= '0;
        end
        S_OUT: if (out_ch.ready) begin
          out_idx <= out_idx + 3'd1;
          if (out_idx == 3'd7) begin
            state <= S_IDLE;
            fill <= '0;
            bit_count <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_ch.valid |-> !in_ch.ready);
  assert property (@(posedge clk) disable iff (rst)
                   state == S_OUT && out_ch.ready && out_idx == 3'd7 |=> state == S_IDLE);
  assert property (@(posedge clk) disable iff (rst) busy |-> !in_ch.ready);
endmodule
`default_nettype wire

// ===== sim/sha256_stream_hasher_top_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sha256_stream_hasher_top_tb;

  // One input transaction as queued for the driver.
  // hold_for_idle makes the driver wait until every digest word is back.
  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       first;
    logic       last;
    bit         hold_for_idle;
  } byte_txn_t;

  // One digest word as it should appear on the output channel.
  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_txn_t;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 450;

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam int unsigned LEN_FIELD_POS = 56;

  logic clk;
  logic rst;

  sha_in_if  in_ch ();
  sha_out_if out_ch ();

  sha256_stream_hasher_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Hash state mirrored by the testbench
  // ---------------------------------------------------------------------------
  logic [31:0] chain_words [8];
  logic [7:0]  msg_block [64];
  int unsigned block_fill;
  logic [63:0] bit_length;

  byte_txn_t   pending_bytes [$];
  digest_txn_t digest_q [$];
  int unsigned mismatches;
  int unsigned cycle_count;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // 64 rounds over msg_block, folded into chain_words
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1, ch, maj;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = chain_words[i];
    for (int i = 0; i < 64; i++) begin
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1  = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) + ch
            + ROUND_CONST[i] + w[i];
      t2  = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) + maj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_words[i] += v[i];
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) chain_words[i] = HASH_IV[i];
    block_fill = 0;
    bit_length = '0;
  endfunction

  // Advance the mirrored hash by one accepted transaction; queue digest words on a last.
  function automatic void absorb_txn(input byte_txn_t t);
    digest_txn_t d;
    if (t.first) restart_hash();
    if (t.present) begin
      msg_block[block_fill] = t.data;
      block_fill++;
      bit_length += 64'd8;
      if (block_fill == 64) begin
        compress_block();
        block_fill = 0;
      end
    end
    if (t.last) begin
      msg_block[block_fill] = PAD_MARK;
      for (int i = block_fill + 1; i < 64; i++) msg_block[i] = 8'h00;
      if (block_fill >= LEN_FIELD_POS) begin
        compress_block();
        for (int i = 0; i < LEN_FIELD_POS; i++) msg_block[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) msg_block[LEN_FIELD_POS + i] = bit_length[63 - 8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        d.word  = chain_words[i];
        d.index = 3'(i);
        d.last  = (i == 7);
        digest_q.push_back(d);
      end
      restart_hash();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_txn(input logic [7:0] data, input logic present,
                                    input logic first, input logic last,
                                    input bit hold = 1'b0);
    byte_txn_t t;
    t.data = data;
    t.present = present;
    t.first = first;
    t.last = last;
    t.hold_for_idle = hold;
    pending_bytes.push_back(t);
  endfunction

  // A message of random bytes; finished on the last byte or by a bare finish.
  // A zero-length message is always a bare finish.
  function automatic void queue_message(input int unsigned len, input bit with_first,
                                        input bit bare_finish);
    for (int i = 0; i < len; i++) begin
      queue_txn(8'($urandom), 1'b1, with_first && (i == 0),
                !bare_finish && (i == len - 1));
    end
    if (bare_finish || len == 0) begin
      queue_txn(8'($urandom), 1'b0, with_first && (len == 0), 1'b1);
    end
  endfunction

  // Mostly short gaps, now and then a long one, with stretches of none at all.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one transaction per handshake, random gaps between them
  // ---------------------------------------------------------------------------
  int unsigned send_gap;
  bit          send_calm;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap <= 0;
      send_calm <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) send_calm <= ~send_calm;
      if (in_ch.valid && !in_ch.ready) begin
        // hold the current transaction
      end else if (send_gap != 0) begin
        in_ch.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_bytes.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (pending_bytes[0].hold_for_idle &&
                   (digest_q.size() != 0 || (in_ch.valid && in_ch.ready))) begin
        // wait until every digest word has come back
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid            <= 1'b1;
        in_ch.message_byte     <= pending_bytes[0].data;
        in_ch.byte_present     <= pending_bytes[0].present;
        in_ch.first_of_message <= pending_bytes[0].first;
        in_ch.last_of_message  <= pending_bytes[0].last;
        void'(pending_bytes.pop_front());
        send_gap <= send_calm ? 0 : pick_gap();
      end
    end
  end

  // Accepted input transactions feed the mirrored hash.
  always @(posedge clk) begin
    byte_txn_t t;
    if (!rst && in_ch.valid && in_ch.ready) begin
      t.data = in_ch.message_byte;
      t.present = in_ch.byte_present;
      t.first = in_ch.first_of_message;
      t.last = in_ch.last_of_message;
      t.hold_for_idle = 1'b0;
      absorb_txn(t);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, compare each digest word with the oldest one due
  // ---------------------------------------------------------------------------
  int unsigned stall_left;
  bit          recv_calm;

  always @(posedge clk) begin
    digest_txn_t d;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
      recv_calm <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) recv_calm <= ~recv_calm;
      if (recv_calm) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left <= pick_gap();
      end

      if (out_ch.valid && out_ch.ready) begin
        if (digest_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected digest word %h index %0d last %b", $realtime,
                     out_ch.digest_word, out_ch.word_index, out_ch.last_word);
        end else begin
          d = digest_q.pop_front();
          if (out_ch.digest_word !== d.word || out_ch.word_index !== d.index ||
              out_ch.last_word !== d.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                       $realtime, d.word, d.index, d.last, out_ch.digest_word,
                       out_ch.word_index, out_ch.last_word);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned len;
    int unsigned r;
    int unsigned base;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.message_byte = '0;
    in_ch.byte_present = 1'b0;
    in_ch.first_of_message = 1'b0;
    in_ch.last_of_message = 1'b0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    restart_hash();
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;

    // Directed: empty message right after reset, with no first flag
    queue_txn(8'h00, 1'b0, 1'b0, 1'b1);
    // "abc"
    queue_txn(8'h61, 1'b1, 1'b1, 1'b0);
    queue_txn(8'h62, 1'b1, 1'b0, 1'b0);
    queue_txn(8'h63, 1'b1, 1'b0, 1'b1);
    // single byte with first and last together, both byte extremes
    queue_txn(8'hff, 1'b1, 1'b1, 1'b1);
    queue_txn(8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
    // empty message with first flag
    queue_txn(8'h5a, 1'b0, 1'b1, 1'b1);
    // a byte, then idle transactions (restart only, and nothing at all), then a last byte
    queue_txn(8'hc3, 1'b1, 1'b0, 1'b0);
    queue_txn(8'h3c, 1'b0, 1'b1, 1'b0);
    queue_txn(8'haa, 1'b0, 1'b0, 1'b0);
    queue_txn(8'h55, 1'b1, 1'b0, 1'b1);
    // message without first flag after a finish, closed by a bare finish
    queue_txn(8'h5a, 1'b1, 1'b0, 1'b0);
    queue_txn(8'ha5, 1'b1, 1'b0, 1'b0);
    queue_txn(8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
    // abandoned partial message, then restart mid-stream
    queue_txn(8'h12, 1'b1, 1'b1, 1'b0);
    queue_txn(8'h34, 1'b1, 1'b1, 1'b0);
    queue_txn(8'h56, 1'b1, 1'b0, 1'b1);

    // Random messages; lengths cluster near the padding boundaries
    base = pending_bytes.size();
    while (pending_bytes.size() - base < RANDOM_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r < 10)      len = $urandom_range(0, 12);
      else if (r < 15) len = $urandom_range(52, 68);
      else if (r < 17) len = $urandom_range(116, 130);
      else             len = $urandom_range(0, 64);
      if ($urandom_range(0, 9) == 0) begin
        // noise: idle transaction or a broken message that gets restarted
        if ($urandom_range(0, 1)) queue_txn(8'($urandom), 1'b0, 1'($urandom), 1'b0);
        else for (int i = 0; i < len % 9; i++) queue_txn(8'($urandom), 1'b1, i == 0, 1'b0);
      end
      queue_message(len, $urandom_range(0, 7) != 0, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 24) == 0) pending_bytes[pending_bytes.size() - 1].hold_for_idle = 1;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait until everything is sent and every digest word has come back
    while (pending_bytes.size() != 0 || in_ch.valid) @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sha256_stream_hasher_top.f =====
rtl/core/sha_pkg.sv
rtl/core/sha_if.sv
rtl/core/sha_compress.sv
rtl/core/sha256_stream_hasher_top.sv
sim/sha256_stream_hasher_top_tb.sv
